/* design/rims_pkg.sv */
// Shared types, codes and constants for the roller intake mode sequencer.
package rims_pkg;

    localparam int unsigned HOLD_TICKS = 200;
    localparam int unsigned HELD_W     = 16;
    localparam int unsigned MAG_W      = 14;
    localparam int unsigned VOLT_W     = 15;
    localparam int unsigned ADDR_W     = 5;

    localparam logic [HELD_W-1:0] HOLD_LIMIT = HOLD_TICKS[HELD_W-1:0];
    localparam logic [HELD_W-1:0] HELD_MAX   = {HELD_W{1'b1}};

    typedef enum logic [2:0] {
        MODE_STOP    = 3'd0,
        MODE_INTAKE  = 3'd1,
        MODE_STRONG  = 3'd2,
        MODE_RETAIN  = 3'd3,
        MODE_OUTTAKE = 3'd4
    } rims_mode_t;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_INTAKE = 3'd1,
        OP_OUT    = 3'd2,
        OP_STOP   = 3'd3,
        OP_HOLD   = 3'd4,
        OP_SELECT = 3'd5,
        OP_SENSOR = 3'd6
    } rims_op_t;

    typedef enum logic [2:0] {
        REG_CONE_IN     = 3'd0,
        REG_CONE_STRONG = 3'd1,
        REG_CONE_KEEP   = 3'd2,
        REG_CONE_OUT    = 3'd3,
        REG_CUBE_IN     = 3'd4,
        REG_CUBE_STRONG = 3'd5,
        REG_CUBE_KEEP   = 3'd6,
        REG_CUBE_OUT    = 3'd7
    } rims_reg_t;

    typedef struct packed {
        logic [MAG_W-1:0]         cone_in_mv;
        logic [MAG_W-1:0]         cone_strong_in_mv;
        logic signed [VOLT_W-1:0] cone_keep_mv;
        logic [MAG_W-1:0]         cone_out_mv;
        logic [MAG_W-1:0]         cube_in_mv;
        logic [MAG_W-1:0]         cube_strong_in_mv;
        logic signed [VOLT_W-1:0] cube_keep_mv;
        logic [MAG_W-1:0]         cube_out_mv;
    } rims_cfg_t;

    typedef struct packed {
        logic sensor_sees_cube;
        logic sensor_sees_cone;
        logic sensor_valid;
        logic is_cone;
        logic hold_on;
        logic force_req;
    } rims_flags_t;

endpackage

/* design/rims_regs.sv */
// APB register file holding the per-piece drive setpoints.
module rims_regs
    import rims_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output rims_cfg_t         cfg
);

    rims_cfg_t cfg_reg;
    logic      wr_en;
    rims_reg_t wr_idx;
    rims_reg_t rd_idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign wr_idx = rims_reg_t'(paddr[ADDR_W-1:2]);
    assign rd_idx = rims_reg_t'(paddr[ADDR_W-1:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            case (wr_idx)
                REG_CONE_IN:     cfg_reg.cone_in_mv        <= pwdata[MAG_W-1:0];
                REG_CONE_STRONG: cfg_reg.cone_strong_in_mv <= pwdata[MAG_W-1:0];
                REG_CONE_KEEP:   cfg_reg.cone_keep_mv      <= pwdata[VOLT_W-1:0];
                REG_CONE_OUT:    cfg_reg.cone_out_mv       <= pwdata[MAG_W-1:0];
                REG_CUBE_IN:     cfg_reg.cube_in_mv        <= pwdata[MAG_W-1:0];
                REG_CUBE_STRONG: cfg_reg.cube_strong_in_mv <= pwdata[MAG_W-1:0];
                REG_CUBE_KEEP:   cfg_reg.cube_keep_mv      <= pwdata[VOLT_W-1:0];
                REG_CUBE_OUT:    cfg_reg.cube_out_mv       <= pwdata[MAG_W-1:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (rd_idx)
            REG_CONE_IN:     prdata = {{(32-MAG_W){1'b0}}, cfg_reg.cone_in_mv};
            REG_CONE_STRONG: prdata = {{(32-MAG_W){1'b0}}, cfg_reg.cone_strong_in_mv};
            REG_CONE_KEEP:   prdata = {{(32-VOLT_W){1'b0}}, cfg_reg.cone_keep_mv};
            REG_CONE_OUT:    prdata = {{(32-MAG_W){1'b0}}, cfg_reg.cone_out_mv};
            REG_CUBE_IN:     prdata = {{(32-MAG_W){1'b0}}, cfg_reg.cube_in_mv};
            REG_CUBE_STRONG: prdata = {{(32-MAG_W){1'b0}}, cfg_reg.cube_strong_in_mv};
            REG_CUBE_KEEP:   prdata = {{(32-VOLT_W){1'b0}}, cfg_reg.cube_keep_mv};
            REG_CUBE_OUT:    prdata = {{(32-MAG_W){1'b0}}, cfg_reg.cube_out_mv};
            default:         prdata = '0;
        endcase
    end

endmodule

/* design/roller_intake_mode_sequencer.sv */
// Top level: command register, mode state machine and drive result register.
// Flow: a command transfer is registered in the input register, then executed from it; a tick's
//   result is registered in the result register and shows on m_tvalid from there.
// Throughput: one command per cycle; the result register stalls the input register
//   only when a tick waits behind an untaken result.
// Reset: synchronous, active low; mode stop, cube selected, no piece, counter zero,
//   all setpoints zero, both channels empty.
module roller_intake_mode_sequencer
    import rims_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,  // force_req, hold_on, is_cone, sensor_valid,
                                        // sensor_sees_cone, sensor_sees_cube, 2 zero
    input  logic [2:0]        s_tuser,  // opcode
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,  // drive_mv[14:0], mode_code[17:15], 6 zero
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    rims_cfg_t cfg;

    logic        in_valid_reg;
    rims_op_t    in_op_reg;
    rims_flags_t in_flags_reg;

    rims_mode_t        mode_reg, mode_next;
    logic              cone_reg, cone_next;
    logic              present_reg, present_next;
    logic [HELD_W-1:0] held_reg, held_next;
    logic [HELD_W-1:0] held_base;

    logic                     out_valid_reg, out_valid_next;
    logic signed [VOLT_W-1:0] out_drive_reg, drive;
    rims_mode_t               out_mode_reg;

    logic is_tick;
    logic stall;
    logic exec;
    logic fire;

    rims_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign is_tick  = (in_op_reg == OP_TICK);
    assign stall    = in_valid_reg && is_tick && out_valid_reg && !m_tready;
    assign exec     = in_valid_reg && !stall;
    assign fire     = exec && is_tick;
    assign s_tready = !stall;

    // hold the command while a tick waits for the result slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (!stall) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg    <= rims_op_t'(s_tuser);
            in_flags_reg <= rims_flags_t'(s_tdata[5:0]);
        end
    end

    always_comb begin
        held_base = (mode_reg == MODE_INTAKE && !present_reg) ? '0 : held_reg;
    end

    // next state
    always_comb begin
        mode_next    = mode_reg;
        cone_next    = cone_reg;
        present_next = present_reg;
        held_next    = held_reg;
        case (in_op_reg)
            OP_TICK: begin
                if (mode_reg == MODE_INTAKE && present_reg && held_reg > HOLD_LIMIT) begin
                    mode_next = MODE_RETAIN;
                end else if (mode_reg == MODE_RETAIN && !present_reg) begin
                    mode_next = MODE_INTAKE;
                end
                held_next = (held_base != HELD_MAX) ? held_base + 1'b1 : held_base;
            end
            OP_INTAKE: begin
                mode_next = (mode_reg == MODE_INTAKE && !in_flags_reg.force_req) ?
                            MODE_STOP : MODE_INTAKE;
            end
            OP_OUT: begin
                mode_next = (mode_reg == MODE_OUTTAKE && !in_flags_reg.force_req) ?
                            MODE_STOP : MODE_OUTTAKE;
            end
            OP_STOP: begin
                mode_next = MODE_STOP;
            end
            OP_HOLD: begin
                if (in_flags_reg.hold_on) begin
                    if (mode_reg inside {MODE_RETAIN, MODE_INTAKE}) begin
                        mode_next = MODE_STRONG;
                    end
                end else if (mode_reg == MODE_STRONG) begin
                    mode_next = MODE_INTAKE;
                end
            end
            OP_SELECT: begin
                cone_next = in_flags_reg.is_cone;
            end
            OP_SENSOR: begin
                if (in_flags_reg.sensor_valid) begin
                    present_next = in_flags_reg.sensor_sees_cone ||
                                   in_flags_reg.sensor_sees_cube;
                end
            end
            default: begin
                mode_next = mode_reg;
            end
        endcase
    end

    // drive output from the mode before the tick
    always_comb begin
        case (mode_reg)
            MODE_INTAKE:  drive = cone_reg ? -$signed({1'b0, cfg.cone_in_mv})
                                           :  $signed({1'b0, cfg.cube_in_mv});
            MODE_STRONG:  drive = cone_reg ? -$signed({1'b0, cfg.cone_strong_in_mv})
                                           :  $signed({1'b0, cfg.cube_strong_in_mv});
            MODE_RETAIN:  drive = cone_reg ? cfg.cone_keep_mv : cfg.cube_keep_mv;
            MODE_OUTTAKE: drive = cone_reg ?  $signed({1'b0, cfg.cone_out_mv})
                                           : -$signed({1'b0, cfg.cube_out_mv});
            default:      drive = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_STOP;
            cone_reg    <= 1'b0;
            present_reg <= 1'b0;
            held_reg    <= '0;
        end else if (exec) begin
            mode_reg    <= mode_next;
            cone_reg    <= cone_next;
            present_reg <= present_next;
            held_reg    <= held_next;
        end
    end

    always_comb begin
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_drive_reg <= drive;
            out_mode_reg  <= mode_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_mode_reg, out_drive_reg};

endmodule

/* design/rims_checker.sv */
// Port-level checks for the roller intake mode sequencer, bound to the top level.
module rims_port_checks
    import rims_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    a_reset_empties: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result channel not empty after reset");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result transfer changed");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a blocked result");

    a_stop_no_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[17:15] == MODE_STOP |-> m_tdata[14:0] == 15'd0)
        else $error("drive in stop mode");

endmodule

bind roller_intake_mode_sequencer rims_port_checks u_rims_port_checks (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* bench/rims_checker.sv */
// Checker for the roller intake mode sequencer: tracks setpoints and mode, compares tick results.
module rims_checker
    import rims_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [7:0]        s_tdata,  // force_req, hold_on, is_cone, sensor_valid,
                                        // sensor_sees_cone, sensor_sees_cube, 2 zero
    input  logic [2:0]        s_tuser,  // opcode
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [23:0]       m_tdata,  // drive_mv[14:0], mode_code[17:15], 6 zero
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    output int unsigned       results_waiting,
    output int                fail_count
);

    typedef struct packed {
        logic [VOLT_W-1:0] drive_mv;
        rims_mode_t        mode_code;
    } tick_result_t;

    tick_result_t      tick_results[$];
    logic [VOLT_W-1:0] setpoint [8];
    rims_mode_t        mode;
    logic              piece_is_cone;
    logic              piece_present;
    logic [HELD_W-1:0] held_ticks;

    initial begin
        fail_count      = 0;
        results_waiting = 0;
    end

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("[%0t] %s mismatch: expected %0d, got %0d", $time, what, want, got);
        fail_count++;
    endtask

    function automatic int magnitude(input rims_reg_t r);
        return int'(setpoint[r][MAG_W-1:0]);
    endfunction

    function automatic int keep_level(input rims_reg_t r);
        return int'($signed(setpoint[r]));
    endfunction

    function automatic int drive_for_mode();
        case (mode)
            MODE_INTAKE:  return piece_is_cone ? -magnitude(REG_CONE_IN) : magnitude(REG_CUBE_IN);
            MODE_STRONG:  return piece_is_cone ? -magnitude(REG_CONE_STRONG)
                                               : magnitude(REG_CUBE_STRONG);
            MODE_RETAIN:  return piece_is_cone ? keep_level(REG_CONE_KEEP)
                                               : keep_level(REG_CUBE_KEEP);
            MODE_OUTTAKE: return piece_is_cone ? magnitude(REG_CONE_OUT) : -magnitude(REG_CUBE_OUT);
            default:      return 0;
        endcase
    endfunction

    task automatic apply_command(input logic [2:0] op, input rims_flags_t fl);
        int           drive;
        tick_result_t res;
        case (op)
            OP_TICK: begin
                drive = drive_for_mode();
                if (mode == MODE_INTAKE) begin
                    if (piece_present) begin
                        if (held_ticks > HOLD_LIMIT) mode = MODE_RETAIN;
                    end else begin
                        held_ticks = '0;
                    end
                end else if (mode == MODE_RETAIN && !piece_present) begin
                    mode = MODE_INTAKE;
                end
                if (held_ticks != HELD_MAX) held_ticks = held_ticks + 1'b1;
                res.drive_mv  = drive[VOLT_W-1:0];
                res.mode_code = mode;
                tick_results.push_back(res);
            end
            OP_INTAKE: mode = (mode == MODE_INTAKE && !fl.force_req) ? MODE_STOP : MODE_INTAKE;
            OP_OUT:    mode = (mode == MODE_OUTTAKE && !fl.force_req) ? MODE_STOP : MODE_OUTTAKE;
            OP_STOP:   mode = MODE_STOP;
            OP_HOLD: begin
                if (fl.hold_on) begin
                    if (mode == MODE_RETAIN || mode == MODE_INTAKE) mode = MODE_STRONG;
                end else if (mode == MODE_STRONG) begin
                    mode = MODE_INTAKE;
                end
            end
            OP_SELECT: piece_is_cone = fl.is_cone;
            OP_SENSOR: begin
                if (fl.sensor_valid) piece_present = fl.sensor_sees_cone || fl.sensor_sees_cube;
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        tick_result_t want;
        rims_reg_t    idx;
        if (!aresetn) begin
            tick_results.delete();
            for (int i = 0; i < 8; i++) setpoint[i] = '0;
            mode          = MODE_STOP;
            piece_is_cone = 1'b0;
            piece_present = 1'b0;
            held_ticks    = '0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                idx = rims_reg_t'(paddr[4:2]);
                if (idx == REG_CONE_KEEP || idx == REG_CUBE_KEEP) begin
                    setpoint[idx] = pwdata[VOLT_W-1:0];
                end else begin
                    setpoint[idx] = {1'b0, pwdata[MAG_W-1:0]};
                end
            end
            if (m_tvalid && m_tready) begin
                if (tick_results.size() == 0) begin
                    report_mismatch("unexpected result, drive_mv", 0,
                                    int'($signed(m_tdata[14:0])));
                end else begin
                    want = tick_results.pop_front();
                    if (m_tdata[14:0] !== want.drive_mv) begin
                        report_mismatch("drive_mv", int'($signed(want.drive_mv)),
                                        int'($signed(m_tdata[14:0])));
                    end
                    if (m_tdata[17:15] !== want.mode_code) begin
                        report_mismatch("mode_code", int'(want.mode_code), int'(m_tdata[17:15]));
                    end
                end
            end
            if (s_tvalid && s_tready) apply_command(s_tuser, rims_flags_t'(s_tdata[5:0]));
        end
        results_waiting <= tick_results.size();
    end

endmodule

/* bench/roller_intake_mode_sequencer_test.sv */
// Testbench top for the roller intake mode sequencer: clock, reset, stimulus and verdict.
module roller_intake_mode_sequencer_test;
    import rims_pkg::*;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata  = '0;  // force_req, hold_on, is_cone, sensor_valid,
                                       // sensor_sees_cone, sensor_sees_cube, 2 zero
    logic [2:0]        s_tuser  = '0;  // opcode
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [23:0]       m_tdata;        // drive_mv[14:0], mode_code[17:15], 6 zero
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [31:0]       pwdata   = '0;
    logic [31:0]       prdata;
    logic              pready;

    int unsigned results_waiting;
    int          fail_count;
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;

    roller_intake_mode_sequencer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    rims_checker u_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .results_waiting (results_waiting),
        .fail_count      (fail_count)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= aresetn && ($urandom_range(99) >= rx_stall_pct);
    end

    function automatic rims_flags_t pack_flags(input logic force_req, input logic hold_on,
                                               input logic is_cone, input logic valid,
                                               input logic sees_cone, input logic sees_cube);
        rims_flags_t fl;
        fl.force_req        = force_req;
        fl.hold_on          = hold_on;
        fl.is_cone          = is_cone;
        fl.sensor_valid     = valid;
        fl.sensor_sees_cone = sees_cone;
        fl.sensor_sees_cube = sees_cube;
        return fl;
    endfunction

    task automatic push_command(input logic [2:0] op, input rims_flags_t fl);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, fl};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic push_ticks(input int n);
        repeat (n) push_command(OP_TICK, rims_flags_t'(6'($urandom_range(63))));
    endtask

    // hold off until every tick result has come back and the block has gone quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_waiting != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_setpoint(input rims_reg_t r, input logic [VOLT_W-1:0] word);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= {17'b0, word};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // 0: full-scale magnitudes and keep extremes, 1: nominal limits, 3: random in range
    task automatic load_setpoints(input int kind);
        rims_reg_t r;
        logic      keep;
        int        v;
        for (int i = 0; i < 8; i++) begin
            r    = rims_reg_t'(i);
            keep = (r == REG_CONE_KEEP || r == REG_CUBE_KEEP);
            case (kind)
                0:       v = keep ? ((r == REG_CONE_KEEP) ? -16384 : 16383) : 16383;
                1:       v = keep ? ((r == REG_CONE_KEEP) ? -12000 : 12000) : 12000;
                default: v = keep ? int'($urandom_range(24000)) - 12000 : int'($urandom_range(12000));
            endcase
            write_setpoint(r, v[VOLT_W-1:0]);
        end
    endtask

    task automatic random_commands(input int n);
        int          sent;
        int          pick;
        bit          paused;
        logic        cone;
        rims_flags_t fl;
        sent   = 0;
        paused = 0;
        while (sent < n) begin
            if (!paused && sent >= n / 2) begin
                settle();
                paused = 1;
            end
            pick = $urandom_range(99);
            fl   = rims_flags_t'(6'($urandom_range(63)));
            if (pick < 8) begin
                cone = $urandom_range(1);
                push_command(OP_SELECT, pack_flags(0, 0, cone, 0, 0, 0));
                push_command(OP_SENSOR, pack_flags(0, 0, 0, 1, cone, !cone));
                push_command(OP_INTAKE, pack_flags(1, 0, 0, 0, 0, 0));
                push_ticks($urandom_range(1, 6));
                push_command(OP_HOLD, pack_flags(0, 1, 0, 0, 0, 0));
                push_ticks(1);
                push_command(OP_HOLD, pack_flags(0, 0, 0, 0, 0, 0));
                push_ticks(1);
                push_command(OP_SENSOR, pack_flags(0, 0, 0, 1, 0, 0));
                push_ticks(2);
                sent += 14;
            end else if (pick < 98) begin
                if (pick < 50) begin
                    push_command(OP_TICK, fl);
                end else if (pick < 58) begin
                    push_command(OP_INTAKE, fl);
                end else if (pick < 64) begin
                    push_command(OP_OUT, fl);
                end else if (pick < 68) begin
                    push_command(OP_STOP, fl);
                end else if (pick < 78) begin
                    push_command(OP_HOLD, fl);
                end else if (pick < 85) begin
                    push_command(OP_SELECT, fl);
                end else begin
                    fl.sensor_valid = ($urandom_range(99) < 85);
                    push_command(OP_SENSOR, fl);
                end
                sent++;
            end else begin
                push_command(3'd7, fl);
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        push_ticks(1);
        push_command(OP_SELECT, pack_flags(0, 0, 1, 0, 0, 0));
        push_command(OP_INTAKE, pack_flags(0, 0, 0, 0, 0, 0));
        push_ticks(1);
        settle();
        load_setpoints(0);

        push_ticks(1);
        push_command(OP_HOLD, pack_flags(0, 1, 0, 0, 0, 0));
        push_ticks(1);
        push_command(OP_HOLD, pack_flags(0, 0, 0, 0, 0, 0));
        push_command(OP_HOLD, pack_flags(0, 0, 0, 0, 0, 0));
        push_ticks(1);
        push_command(OP_SELECT, pack_flags(0, 0, 0, 0, 0, 0));
        push_ticks(1);
        push_command(OP_INTAKE, pack_flags(0, 0, 0, 0, 0, 0));
        push_ticks(1);
        push_command(OP_HOLD, pack_flags(0, 1, 0, 0, 0, 0));
        push_command(OP_OUT, pack_flags(0, 0, 0, 0, 0, 0));
        push_ticks(1);
        push_command(OP_OUT, pack_flags(1, 0, 0, 0, 0, 0));
        push_ticks(1);
        push_command(OP_OUT, pack_flags(0, 0, 0, 0, 0, 0));
        push_ticks(1);
        push_command(OP_SELECT, pack_flags(0, 0, 1, 0, 0, 0));
        push_command(OP_OUT, pack_flags(0, 0, 0, 0, 0, 0));
        push_ticks(1);
        push_command(OP_SENSOR, pack_flags(0, 0, 0, 0, 1, 1));
        push_command(3'd7, pack_flags(1, 1, 1, 1, 1, 1));
        push_command(OP_INTAKE, pack_flags(1, 0, 0, 0, 0, 0));
        push_ticks(1);
        push_command(OP_STOP, pack_flags(0, 0, 0, 0, 0, 0));
        push_ticks(1);
        settle();
        load_setpoints(1);

        // hold-time threshold: clear the counter in intake, then tick across it
        push_command(OP_SELECT, pack_flags(0, 0, 0, 0, 0, 0));
        push_command(OP_SENSOR, pack_flags(0, 0, 0, 1, 0, 0));
        push_command(OP_INTAKE, pack_flags(1, 0, 0, 0, 0, 0));
        push_ticks(1);
        push_command(OP_SENSOR, pack_flags(0, 0, 0, 1, 0, 1));
        push_ticks(205);
        push_command(OP_HOLD, pack_flags(0, 1, 0, 0, 0, 0));
        push_ticks(1);
        push_command(OP_HOLD, pack_flags(0, 0, 0, 0, 0, 0));
        push_ticks(1);
        push_command(OP_SENSOR, pack_flags(0, 0, 0, 1, 0, 0));
        push_ticks(2);

        // run the counter in stop, then enter intake with a cone and lose it
        push_command(OP_STOP, pack_flags(0, 0, 0, 0, 0, 0));
        push_command(OP_SELECT, pack_flags(0, 0, 1, 0, 0, 0));
        push_command(OP_SENSOR, pack_flags(0, 0, 0, 1, 1, 0));
        push_ticks(10);
        push_command(OP_INTAKE, pack_flags(1, 0, 0, 0, 0, 0));
        push_ticks(2);
        push_command(OP_SENSOR, pack_flags(0, 0, 0, 1, 0, 0));
        push_ticks(2);

        for (int ph = 0; ph < 4; ph++) begin
            settle();
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  load_setpoints(3); end
                1: begin tx_idle_pct = 79; rx_stall_pct = 0;  load_setpoints(0); end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 79; load_setpoints(3); end
                default: begin tx_idle_pct = 13; rx_stall_pct = 13; load_setpoints(1); end
            endcase
            random_commands(120);
        end

        settle();
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
design/rims_pkg.sv
design/rims_regs.sv
design/roller_intake_mode_sequencer.sv
design/rims_checker.sv
bench/rims_checker.sv
bench/roller_intake_mode_sequencer_test.sv
